/* hw/rtl/bvc_pkg.sv */
// ----------------------------------------------------------------------------
// bvc_pkg
// Shared types, constants and colour mapping for the bit-plane video core.
// ----------------------------------------------------------------------------
package bvc_pkg;

   localparam int NUM_PLANES = 6;
   localparam int NUM_PIXELS = 8;
   localparam int PAL_WORDS  = 7;

   typedef enum logic [1:0] {
      OP_PORT_WRITE = 2'd0,
      OP_MEM_WRITE  = 2'd1,
      OP_MEM_READ   = 2'd2,
      OP_RENDER     = 2'd3
   } op_type;

   localparam logic [7:0] PORT_READ_BANK  = 8'hf1;
   localparam logic [7:0] PORT_WRITE_MASK = 8'hf2;
   localparam logic [7:0] PORT_PAL_FIRST  = 8'hf5;
   localparam logic [7:0] PORT_PAL_LAST   = 8'hfb;
   localparam logic [7:0] PORT_BACKDROP   = 8'hfc;
   localparam logic [7:0] PORT_ENABLE     = 8'hfe;

   // Palette view handed to every pixel lane
   typedef struct packed {
      logic [7:0]  word0;
      logic [7:0]  word1;
      logic [7:0]  word2;
      logic [7:0]  mask;
      logic [23:0] backdrop_rgb;
   } lane_cfg_type;

   // One channel level from its low and high colour bits
   function automatic logic [7:0] chan_level(input logic lo, input logic hi);
      logic [7:0] lvl;
      if (lo && hi) begin
         lvl = 8'hff;
      end else if (lo) begin
         lvl = 8'h7f;
      end else begin
         lvl = 8'h00;
      end
      return lvl;
   endfunction

   // Colour byte to RGB: red from bits 0/4, green 1/5, blue 2/6
   function automatic logic [23:0] to_rgb(input logic [7:0] v);
      return {chan_level(v[0], v[4]), chan_level(v[1], v[5]), chan_level(v[2], v[6])};
   endfunction

endpackage

/* hw/rtl/bvc_plane_ram.sv */
// ----------------------------------------------------------------------------
// bvc_plane_ram
// One bit plane: single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module bvc_plane_ram #(
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [7:0]               wr_data,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bvc_pixel_lane.sv */
// ----------------------------------------------------------------------------
// bvc_pixel_lane
// One pixel: picks foreground, background or backdrop and maps it to RGB.
// ----------------------------------------------------------------------------
module bvc_pixel_lane
   import bvc_pkg::*;
(
   input  logic [2:0]   fg_code,
   input  logic [2:0]   bg_code,
   input  lane_cfg_type cfg,
   output logic [23:0]  rgb
);

   logic [2:0] code;
   logic [7:0] mix;
   logic [7:0] colour;

   always_comb begin
      code = (fg_code != 3'd0) ? fg_code : bg_code;
      mix  = (code[0] ? cfg.word0 : 8'h00) |
             (code[1] ? cfg.word1 : 8'h00) |
             (code[2] ? cfg.word2 : 8'h00);
      // mask only applies where the mix overlaps it
      colour = ((mix & cfg.mask) != 8'h00) ? (mix & cfg.mask) : mix;
      rgb    = (code != 3'd0) ? to_rgb(colour) : cfg.backdrop_rgb;
   end

endmodule

/* hw/rtl/bitplane_video_controller_core.sv */
// ----------------------------------------------------------------------------
// bitplane_video_controller_core
// Six-plane bitmap video controller with port registers and pixel render.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_operation/req_port/req_offset/req_data and raise start;
//   the transfer happens on the edge where start is high and busy is low.
//   Port writes (operation 0) update the registers at that edge. Memory
//   writes (1) run offset wrap, then the write into every plane selected
//   by the write mask.
//   Memory reads (2) and renders (3) run offset wrap, plane read (all six
//   planes in parallel), eight pixel lanes plus merge into the result
//   register, then rsp_valid is high for one cycle with the result; busy
//   is already low in that cycle so the next item may start.
//   These steps are the ST_ADDR, ST_ACCESS and ST_LANE states.
//   The receiver cannot stall: each result is taken in its strobe cycle.
//   Reset (synchronous, active high) clears the registers and then runs a
//   clearing pass over every plane byte with busy high.
// ----------------------------------------------------------------------------
module bitplane_video_controller_core
   import bvc_pkg::*;
#(
   parameter int PLANE_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_port,
   input  logic [12:0] req_offset,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic [23:0] rsp_pixel_0,
   output logic [23:0] rsp_pixel_1,
   output logic [23:0] rsp_pixel_2,
   output logic [23:0] rsp_pixel_3,
   output logic [23:0] rsp_pixel_4,
   output logic [23:0] rsp_pixel_5,
   output logic [23:0] rsp_pixel_6,
   output logic [23:0] rsp_pixel_7
);

   localparam int ADDR_W = $clog2(PLANE_BYTES);
   localparam logic [18:0] SPAN_1 = 19'(PLANE_BYTES);
   localparam logic [18:0] SPAN_2 = 19'(PLANE_BYTES * 2);
   localparam logic [18:0] SPAN_4 = 19'(PLANE_BYTES * 4);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(PLANE_BYTES - 1);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_ADDR   = 5'b00100,
      ST_ACCESS = 5'b01000,
      ST_LANE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [1:0]        op_ff;
   logic [12:0]       offset_ff;
   logic [7:0]        data_ff;

   logic [7:0] read_bank_ff;
   logic [5:0] write_mask_ff;
   logic [5:0] enable_ff;
   logic [7:0] palette_ff [PAL_WORDS];
   logic [7:0] backdrop_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_data_ff, rsp_read_data_in;
   logic [23:0] rsp_pixel_ff [NUM_PIXELS];
   logic [23:0] rsp_pixel_in [NUM_PIXELS];

   logic              accept;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata;
   logic [5:0]        ram_we;
   logic [7:0]        ram_rdata [NUM_PLANES];
   logic [7:0]        plane_bits [NUM_PLANES];
   logic [23:0]       lane_rgb [NUM_PIXELS];
   logic [7:0]        bank_data;
   lane_cfg_type      lane_cfg;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // ---- sequencer ----
   always_comb begin
      logic [18:0] rem;
      state_in = state_ff;
      clr_in   = clr_ff;
      rem      = 19'(offset_ff);
      // wrap offset into a plane: quotient is below eight
      if (rem >= SPAN_4) begin
         rem = rem - SPAN_4;
      end
      if (rem >= SPAN_2) begin
         rem = rem - SPAN_2;
      end
      if (rem >= SPAN_1) begin
         rem = rem - SPAN_1;
      end
      addr_in = rem[ADDR_W-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (op_type'(req_operation) != OP_PORT_WRITE)) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            state_in = (op_type'(op_ff) == OP_MEM_WRITE) ? ST_IDLE : ST_LANE;
         end
         ST_LANE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // hold the accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         offset_ff <= req_offset;
         data_ff   <= req_data;
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= addr_in;
      end
   end

   // ---- port registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         read_bank_ff  <= '0;
         write_mask_ff <= '0;
         enable_ff     <= '0;
         backdrop_ff   <= '0;
         for (int i = 0; i < PAL_WORDS; i++) begin
            palette_ff[i] <= '0;
         end
      end else if (accept && (op_type'(req_operation) == OP_PORT_WRITE)) begin
         priority if (req_port == PORT_READ_BANK) begin
            read_bank_ff <= req_data;
         end else if (req_port == PORT_WRITE_MASK) begin
            write_mask_ff <= req_data[5:0];
         end else if ((req_port >= PORT_PAL_FIRST) && (req_port <= PORT_PAL_LAST)) begin
            palette_ff[3'(req_port - PORT_PAL_FIRST)] <= req_data;
         end else if (req_port == PORT_BACKDROP) begin
            backdrop_ff <= req_data;
         end else if (req_port == PORT_ENABLE) begin
            enable_ff <= req_data[5:0];
         end else begin
            // drop writes to unlisted ports
         end
      end
   end

   // ---- plane memories ----
   assign ram_addr  = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? 8'h00 : data_ff;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we = '1;
      end else if ((state_ff == ST_ACCESS) && (op_type'(op_ff) == OP_MEM_WRITE)) begin
         ram_we = write_mask_ff;
      end else begin
         ram_we = '0;
      end
   end

   for (genvar k = 0; k < NUM_PLANES; k++) begin : g_plane
      bvc_plane_ram #(
         .DEPTH (PLANE_BYTES)
      ) u_plane (
         .clock   (clock),
         .wr_en   (ram_we[k]),
         .addr    (ram_addr),
         .wr_data (ram_wdata),
         .rd_data (ram_rdata[k])
      );
      assign plane_bits[k] = enable_ff[k] ? ram_rdata[k] : 8'h00;
   end

   // ---- pixel lanes ----
   assign lane_cfg.word0        = palette_ff[0];
   assign lane_cfg.word1        = palette_ff[1];
   assign lane_cfg.word2        = palette_ff[2];
   assign lane_cfg.mask         = palette_ff[6];
   assign lane_cfg.backdrop_rgb = to_rgb(backdrop_ff);

   for (genvar p = 0; p < NUM_PIXELS; p++) begin : g_lane
      bvc_pixel_lane u_lane (
         .fg_code ({plane_bits[2][p], plane_bits[1][p], plane_bits[0][p]}),
         .bg_code ({plane_bits[5][p], plane_bits[4][p], plane_bits[3][p]}),
         .cfg     (lane_cfg),
         .rgb     (lane_rgb[p])
      );
   end

   // ---- merge into the result register ----
   always_comb begin
      bank_data = 8'hff;
      for (int k = 0; k < NUM_PLANES; k++) begin
         if (read_bank_ff == 8'(k + 1)) begin
            bank_data = ram_rdata[k];
         end
      end
      rsp_valid_in     = (state_ff == ST_LANE);
      rsp_read_data_in = (op_type'(op_ff) == OP_MEM_READ) ? bank_data : 8'h00;
      for (int p = 0; p < NUM_PIXELS; p++) begin
         rsp_pixel_in[p] = (op_type'(op_ff) == OP_RENDER) ? lane_rgb[p] : 24'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LANE) begin
         rsp_read_data_ff <= rsp_read_data_in;
         for (int p = 0; p < NUM_PIXELS; p++) begin
            rsp_pixel_ff[p] <= rsp_pixel_in[p];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_pixel_0   = rsp_pixel_ff[0];
   assign rsp_pixel_1   = rsp_pixel_ff[1];
   assign rsp_pixel_2   = rsp_pixel_ff[2];
   assign rsp_pixel_3   = rsp_pixel_ff[3];
   assign rsp_pixel_4   = rsp_pixel_ff[4];
   assign rsp_pixel_5   = rsp_pixel_ff[5];
   assign rsp_pixel_6   = rsp_pixel_ff[6];
   assign rsp_pixel_7   = rsp_pixel_ff[7];

endmodule
